// ===== hdl/bdms_pkg.sv =====
// ----------------------------------------------------------------------------
// bdms_pkg
// Shared widths, register map and divider interface types for the
// bounded-delay minimum service rate block.
// ----------------------------------------------------------------------------
package bdms_pkg;

   // Every fixed-point field of a segment and of a result is one word.
   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(WORD_W);

   // Configuration port: one register, word aligned.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_DELAY = 1'b0;

   // Reset value of the delay register: 1.0 time unit at 16 fraction bits.
   localparam logic [WORD_W-1:0] DELAY_RESET = 32'h0001_0000;

   localparam logic [WORD_W-1:0] WORD_MAX = '1;

   // Start command to the shared divider. The high numerator word must be
   // below the divisor, so the quotient fits in one word.
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] num_hi;
      logic [WORD_W-1:0] num_lo;
      logic [WORD_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WORD_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== hdl/bdms_div.sv =====
// ----------------------------------------------------------------------------
// bdms_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bdms_div
   import bdms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   // Upper word holds the partial remainder, lower word the dividend bits
   // still to come, which are replaced by quotient bits as they shift out.
   logic [2*WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [WORD_W:0]     shifted_rem;
   logic [WORD_W+1:0]   trial;
   logic                borrow;

   always_comb begin
      shifted_rem = {acc_ff[2*WORD_W-1:WORD_W], acc_ff[WORD_W-1]};
      trial       = {1'b0, shifted_rem} - {2'b00, den_ff};
      borrow      = trial[WORD_W+1];

      acc_in   = acc_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (div_req.start) begin
         acc_in   = {div_req.num_hi, div_req.num_lo};
         den_in   = div_req.den;
         count_in = CNT_W'(WORD_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (borrow) begin
            acc_in = {shifted_rem[WORD_W-1:0], acc_ff[WORD_W-2:0], 1'b0};
         end else begin
            acc_in = {trial[WORD_W-1:0], acc_ff[WORD_W-2:0], 1'b1};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = acc_ff[WORD_W-1:0];

endmodule

// ===== hdl/bounded_delay_min_speed.sv =====
// ----------------------------------------------------------------------------
// bounded_delay_min_speed
// Least rate of a bounded-delay service curve that still bounds a
// piecewise-linear input curve, given one segment per request.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the req_ channel carries one curve segment: its start time,
// start value and slope, all unsigned fixed point with FRAC_BITS fraction
// bits, plus a flag marking the final segment of the curve. The block keeps a
// running maximum of per-segment rate candidates and, on the final segment,
// sends one request on the rsp_ channel with the minimum rate and a flag that
// tells whether a nonzero segment at or before the delay forced the rate to
// 1.0. Running maximum and flag are then cleared for the next curve.
// A segment past the delay runs the shared shift-subtract divider, one
// quotient bit per cycle: after the segment is accepted, the block classifies
// it and starts the divider, waits through the 32 divider steps, takes the
// quotient and finishes, and only then accepts the next segment. A segment
// that needs no division goes from classification straight to finishing.
// The result sits in an output register; if the receiver stalls, the block
// keeps accepting segments and only waits when a further final segment is
// done while the earlier result has not yet been taken.
// Reset (synchronous) sets the delay register to 1.0 at 16 fraction bits, clears
// the running state and drops rsp_valid. The delay register is written over the csr_ port.
// ----------------------------------------------------------------------------
module bounded_delay_min_speed
   import bdms_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_W-1:0]     req_seg_x,
   input  logic [WORD_W-1:0]     req_seg_y,
   input  logic [WORD_W-1:0]     req_seg_slope,
   input  logic                  req_seg_last,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_W-1:0]     rsp_min_speed,
   output logic                  rsp_forced_full,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [WORD_W-1:0]     csr_pwdata,
   output logic [WORD_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   // Exactly 1.0 in the configured fixed-point format.
   localparam logic [WORD_W-1:0] RATE_ONE = WORD_W'(1) << FRAC_BITS;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a segment
   localparam logic [1:0] ST_EVAL = 2'd1;  // classify the latched segment
   localparam logic [1:0] ST_DIV  = 2'd2;  // divider running
   localparam logic [1:0] ST_DONE = 2'd3;  // emit on a final segment

   logic [1:0]        state_ff, state_in;
   logic [WORD_W-1:0] delay_ff, delay_in;
   logic [WORD_W-1:0] max_ff, max_in;
   logic              forced_ff, forced_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [WORD_W-1:0] seg_x_ff, seg_y_ff, seg_slope_ff;
   logic              seg_last_ff;
   logic [WORD_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic              rsp_forced_ff, rsp_forced_in;

   logic              req_fire;
   logic              csr_write;
   logic [WORD_W-1:0] gap;
   logic [WORD_W-1:0] y_hi, y_lo;
   logic              past_delay;
   logic              quot_overflow;
   logic [WORD_W-1:0] cand;
   logic              cand_valid;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   // ---------------------------------------------------------------------
   // Configuration port. Only the word index is decoded; pready is tied.
   // ---------------------------------------------------------------------
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      delay_in = delay_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_DELAY)) begin
         delay_in = csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_DELAY) begin
         csr_prdata = delay_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Segment classification. The numerator is seg_y shifted left by the
   // fraction width; its upper word tells at once whether the quotient
   // overflows one word, so the divider only ever runs 32 steps.
   // ---------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign past_delay    = seg_x_ff > delay_ff;
   assign gap           = seg_x_ff - delay_ff;
   assign y_hi          = WORD_W'(seg_y_ff >> (WORD_W - FRAC_BITS));
   assign y_lo          = WORD_W'(seg_y_ff << FRAC_BITS);
   assign quot_overflow = y_hi >= gap;

   always_comb begin
      state_in      = state_ff;
      max_in        = max_ff;
      forced_in     = forced_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_speed_in  = rsp_speed_ff;
      rsp_forced_in = rsp_forced_ff;
      cand          = '0;
      cand_valid    = 1'b0;

      div_req.start  = 1'b0;
      div_req.num_hi = y_hi;
      div_req.num_lo = y_lo;
      div_req.den    = gap;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_DONE;
            if (!forced_ff) begin
               if (past_delay) begin
                  if (quot_overflow) begin
                     // Saturated quotient is never below the slope.
                     cand       = WORD_MAX;
                     cand_valid = 1'b1;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end else if (seg_y_ff != '0) begin
                  // A nonzero value before the delay pins the rate at 1.0
                  // and freezes the rest of this curve.
                  max_in    = RATE_ONE;
                  forced_in = 1'b1;
               end else begin
                  cand       = seg_slope_ff;
                  cand_valid = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               cand       = (seg_slope_ff > div_rsp.quot) ? seg_slope_ff : div_rsp.quot;
               cand_valid = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!seg_last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_speed_in  = max_ff;
               rsp_forced_in = forced_ff;
               max_in        = '0;
               forced_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cand_valid && (cand > max_ff)) begin
         max_in = cand;
      end
   end

   bdms_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_ff     <= DELAY_RESET;
         max_ff       <= '0;
         forced_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         max_ff       <= max_in;
         forced_ff    <= forced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         seg_x_ff     <= req_seg_x;
         seg_y_ff     <= req_seg_y;
         seg_slope_ff <= req_seg_slope;
         seg_last_ff  <= req_seg_last;
      end
      rsp_speed_ff  <= rsp_speed_in;
      rsp_forced_ff <= rsp_forced_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_speed   = rsp_speed_ff;
   assign rsp_forced_full = rsp_forced_ff;

endmodule

// ===== hdl/bdms_checker.sv =====
// ----------------------------------------------------------------------------
// bdms_checker
// Port-level checks for the bounded-delay minimum service rate block.
// ----------------------------------------------------------------------------
module bdms_checker
   import bdms_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_min_speed,
   input logic              rsp_forced_full
);

   localparam logic [WORD_W-1:0] RATE_ONE = WORD_W'(1) << FRAC_BITS;

   // A held result does not change until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_speed)
         && $stable(rsp_forced_full))
      else $error("result changed or dropped while stalled");

   // Accepting a segment moves the block out of idle, so it is busy right after one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // A forced curve always reports exactly 1.0.
   a_forced_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forced_full |-> rsp_min_speed == RATE_ONE)
      else $error("forced result is not 1.0");

   // After reset the block is idle with no pending result.
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind bounded_delay_min_speed bdms_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_bdms_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_min_speed   (rsp_min_speed),
   .rsp_forced_full (rsp_forced_full)
);
